@@ hdl/dest_pkg.sv @@
// ----------------------------------------------------------------------------
// dest_pkg
// Shared constants, types and codes of the deadline event slot table.
// ----------------------------------------------------------------------------
`default_nettype none

package dest_pkg;

  // Table geometry.
  localparam int SLOTS   = 32;
  localparam int SLOT_AW = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);

  // Field widths.
  localparam int HANDLE_W = 16;
  localparam int TIME_W   = 48;
  localparam int GRACE_W  = 24;
  localparam int KIND_W   = 2;
  localparam int COUNT_W  = 7;

  // Item modes.
  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIRED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

  // Add status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   deadline;
    logic [GRACE_W-1:0]  grace;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  typedef struct packed {
    logic load;        // capture a new item
    logic idx_inc;     // step the add scan
    logic write_slot;  // store the item at the scan index
    logic hw_inc;      // raise the high-water mark
    logic hw_dec;      // lower the high-water mark
    logic set_full;    // remember a dropped add
    logic rd_issue;    // read the slot at the scan index
    logic pend_drop;   // retire the pending slot read once the scan is done
    logic fire;        // emit the pending slot and empty it
    logic emit_ack;
    logic emit_fin;
  } dp_cmd_t;

  typedef struct packed {
    logic new_update;  // mode of the item offered at the input
    logic handle_zero;
    logic scan_done;
    logic slot_occ;
    logic full;
    logic pend;
    logic pend_fire;
    logic trim_stop;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ hdl/dest_if.sv @@
// ----------------------------------------------------------------------------
// dest_if
// Valid/ready channels for event requests and table results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dest_in_if;
  import dest_pkg::*;

  logic                valid;
  logic                ready;
  logic                mode;
  logic [HANDLE_W-1:0] handle;
  logic [TIME_W-1:0]   deadline;
  logic [GRACE_W-1:0]  grace;
  logic [TIME_W-1:0]   now;

  modport source (output valid, mode, handle, deadline, grace, now, input ready);
  modport sink   (input valid, mode, handle, deadline, grace, now, output ready);
endinterface

interface dest_out_if;
  import dest_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [HANDLE_W-1:0] fired_handle;
  logic                status;
  logic [COUNT_W-1:0]  fired_count;
  logic [COUNT_W-1:0]  used_slots;
  logic                last;

  modport source (output valid, kind, fired_handle, status, fired_count, used_slots, last,
                  input ready);
  modport sink   (input valid, kind, fired_handle, status, fired_count, used_slots, last,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/deadline_event_slot_table.sv @@
// ----------------------------------------------------------------------------
// deadline_event_slot_table
// Fixed table of timed events with add and update requests.
// ----------------------------------------------------------------------------
// One request is processed at a time. An add walks the occupancy bits from
// slot 0, one slot per cycle, to the first empty slot or the high-water mark,
// and its acknowledge is emitted once the output register is free; the next
// request is accepted only after that. An update reads every slot below the
// mark through the single read port of the slot RAM, one slot per cycle
// while no firing slot waits for the output register, emits each occupied
// slot whose deadline lies before now plus its grace, then lowers the mark
// by one per cycle over empty top slots. Its finished result is emitted once
// the output register is free. A new request is taken while the last result
// still waits in the output register.
`default_nettype none

module deadline_event_slot_table (
  input wire logic  clk,
  input wire logic  rst,
  dest_in_if.sink   item,
  dest_out_if.source result
);
  import dest_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  dest_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .status   (status),
    .cmd      (cmd)
  );

  dest_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .in_mode          (item.mode),
    .in_handle        (item.handle),
    .in_deadline      (item.deadline),
    .in_grace         (item.grace),
    .in_now           (item.now),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .out_kind         (result.kind),
    .out_fired_handle (result.fired_handle),
    .out_status       (result.status),
    .out_fired_count  (result.fired_count),
    .out_used_slots   (result.used_slots),
    .out_last         (result.last),
    .cmd              (cmd),
    .status           (status)
  );

endmodule

`default_nettype wire

@@ hdl/dest_ram.sv @@
// ----------------------------------------------------------------------------
// dest_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dest_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/dest_ctrl.sv @@
// ----------------------------------------------------------------------------
// dest_ctrl
// Sequencer for add scans, update scans, mark trimming and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module dest_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire dest_pkg::dp_status_t status,
  output      dest_pkg::dp_cmd_t    cmd
);
  import dest_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD  = 3'd1;
  localparam logic [2:0] S_ACK  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_TRIM = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       stall;

  // A slot that fires must wait until the output register can take it.
  assign stall = status.pend && status.pend_fire && !status.out_free;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.new_update ? S_UPD : S_ADD;
        end
      end
      S_ADD: begin
        if (status.handle_zero) begin
          state_next = S_ACK;
        end else if (status.scan_done) begin
          if (status.full) begin
            cmd.set_full = 1'b1;
          end else begin
            cmd.write_slot = 1'b1;
            cmd.hw_inc     = 1'b1;
          end
          state_next = S_ACK;
        end else if (status.slot_occ) begin
          cmd.idx_inc = 1'b1;
        end else begin
          cmd.write_slot = 1'b1;
          state_next     = S_ACK;
        end
      end
      S_ACK: begin
        if (status.out_free) begin
          cmd.emit_ack = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_UPD: begin
        if (!stall) begin
          cmd.fire = status.pend && status.pend_fire;
          if (!status.scan_done) begin
            cmd.rd_issue = 1'b1;
          end else if (status.pend) begin
            cmd.pend_drop = 1'b1;
          end else begin
            state_next = S_TRIM;
          end
        end
      end
      S_TRIM: begin
        if (status.trim_stop) begin
          state_next = S_FIN;
        end else begin
          cmd.hw_dec = 1'b1;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.emit_fin = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/dest_dp.sv @@
// ----------------------------------------------------------------------------
// dest_dp
// Slot storage, occupancy bits, high-water mark, scan index and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dest_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_mode,
  input  wire logic [dest_pkg::HANDLE_W-1:0] in_handle,
  input  wire logic [dest_pkg::TIME_W-1:0]   in_deadline,
  input  wire logic [dest_pkg::GRACE_W-1:0]  in_grace,
  input  wire logic [dest_pkg::TIME_W-1:0]   in_now,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [dest_pkg::KIND_W-1:0]   out_kind,
  output      logic [dest_pkg::HANDLE_W-1:0] out_fired_handle,
  output      logic                          out_status,
  output      logic [dest_pkg::COUNT_W-1:0]  out_fired_count,
  output      logic [dest_pkg::COUNT_W-1:0]  out_used_slots,
  output      logic                          out_last,
  input  wire dest_pkg::dp_cmd_t             cmd,
  output      dest_pkg::dp_status_t          status
);
  import dest_pkg::*;

  // Captured item.
  logic [HANDLE_W-1:0] handle;
  logic [TIME_W-1:0]   deadline;
  logic [GRACE_W-1:0]  grace;
  logic [TIME_W-1:0]   now;

  logic [SLOTS-1:0]    occ;
  logic [CNT_W-1:0]    hw;
  logic [CNT_W-1:0]    hw_m1;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    count;
  logic                full_flag;
  logic                pend;
  logic                pend_occ;
  logic [SLOT_AW-1:0]  pend_idx;

  slot_entry_t         wr_entry;
  logic [ENTRY_W-1:0]  rd_raw;
  slot_entry_t         rd_entry;
  logic [TIME_W:0]     limit;

  assign wr_entry.handle   = handle;
  assign wr_entry.deadline = deadline;
  assign wr_entry.grace    = grace;
  assign rd_entry          = slot_entry_t'(rd_raw);

  dest_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (cmd.write_slot),
    .waddr (idx[SLOT_AW-1:0]),
    .wdata (wr_entry),
    .re    (cmd.rd_issue),
    .raddr (idx[SLOT_AW-1:0]),
    .rdata (rd_raw)
  );

  // The sum is one bit wider than a time so that it never wraps.
  assign limit = {1'b0, now} + {{(TIME_W + 1 - GRACE_W){1'b0}}, rd_entry.grace};
  assign hw_m1 = hw - CNT_W'(1);

  assign status.new_update  = (in_mode == MODE_UPDATE);
  assign status.handle_zero = (handle == '0);
  assign status.scan_done   = (idx == hw);
  assign status.slot_occ    = occ[idx[SLOT_AW-1:0]];
  assign status.full        = (hw == CNT_W'(SLOTS));
  assign status.pend        = pend;
  assign status.pend_fire   = pend_occ && ({1'b0, rd_entry.deadline} < limit);
  assign status.trim_stop   = (hw == '0) || occ[hw_m1[SLOT_AW-1:0]];
  assign status.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      handle   <= in_handle;
      deadline <= in_deadline;
      grace    <= in_grace;
      now      <= in_now;
    end
    if (cmd.rd_issue) begin
      pend_idx <= idx[SLOT_AW-1:0];
      pend_occ <= occ[idx[SLOT_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      hw        <= '0;
      idx       <= '0;
      count     <= '0;
      full_flag <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx       <= '0;
        count     <= '0;
        full_flag <= 1'b0;
        pend      <= 1'b0;
      end
      if (cmd.idx_inc || cmd.rd_issue) begin
        idx <= idx + CNT_W'(1);
      end
      if (cmd.rd_issue) begin
        pend <= 1'b1;
      end else if (cmd.pend_drop) begin
        pend <= 1'b0;
      end
      if (cmd.write_slot) begin
        occ[idx[SLOT_AW-1:0]] <= 1'b1;
      end
      if (cmd.fire) begin
        occ[pend_idx] <= 1'b0;
        count         <= count + CNT_W'(1);
      end
      if (cmd.hw_inc) begin
        hw <= hw + CNT_W'(1);
      end else if (cmd.hw_dec) begin
        hw <= hw_m1;
      end
      if (cmd.set_full) begin
        full_flag <= 1'b1;
      end
    end
  end

  // Output register: holds one result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_ack || cmd.fire || cmd.emit_fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ack) begin
      out_kind         <= KIND_ACK;
      out_fired_handle <= '0;
      out_status       <= full_flag ? STATUS_FULL : STATUS_OK;
      out_fired_count  <= '0;
      out_used_slots   <= COUNT_W'(hw);
      out_last         <= 1'b1;
    end else if (cmd.fire) begin
      out_kind         <= KIND_FIRED;
      out_fired_handle <= rd_entry.handle;
      out_status       <= STATUS_OK;
      out_fired_count  <= '0;
      out_used_slots   <= COUNT_W'(hw);
      out_last         <= 1'b0;
    end else if (cmd.emit_fin) begin
      out_kind         <= KIND_DONE;
      out_fired_handle <= '0;
      out_status       <= STATUS_OK;
      out_fired_count  <= COUNT_W'(count);
      out_used_slots   <= COUNT_W'(hw);
      out_last         <= 1'b1;
    end
  end

endmodule

`default_nettype wire
